### sv/fcd_pkg.sv
// Fractional clock divider solver: shared types and constants.
// No dependencies.
package fcd_pkg;

    localparam int SRC_W  = 28;
    localparam int RATE_W = 26;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;

    localparam logic [RATE_W-1:0] MIN_RATE = 26'd80;
    localparam logic [9:0]        DIV_MAX  = 10'd1023;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;       // capture rate, compute interval
        logic div_start;  // start a divide
        logic [1:0] div_sel; // which divide
        logic cand_init;  // reset search
        logic cand_eval;  // evaluate candidate from divider result
        logic out_load;   // load result register
    } fcd_cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic div_done;
        logic bad_low;
        logic bad_high;
        logic mod_zero;
        logic search_end;
    } fcd_stat_t;

    localparam logic [1:0] DSEL_SCALE = 2'd0;
    localparam logic [1:0] DSEL_QUOT  = 2'd1;
    localparam logic [1:0] DSEL_ROUND = 2'd2;

endpackage

### sv/fcd_if.sv
// Valid/ready channel interfaces for the divider solver.
// Depends on fcd_pkg.
interface fcd_in_if import fcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] target_rate_hz;
    modport source (output valid, output target_rate_hz, input ready);
    modport sink   (input valid, input target_rate_hz, output ready);
endinterface

interface fcd_out_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] trigger_interval;
    logic [9:0]  integer_divider;
    logic [5:0]  frac_numerator;
    logic [5:0]  frac_denominator;
    modport source (output valid, output status, output trigger_interval,
        output integer_divider, output frac_numerator, output frac_denominator,
        input ready);
    modport sink (input valid, input status, input trigger_interval,
        input integer_divider, input frac_numerator, input frac_denominator,
        output ready);
endinterface

### sv/fractional_clock_divider_solver_core.sv
// Top level of the fractional clock divider solver.
// Depends on fcd_pkg, fcd_if, fcd_ctrl, fcd_datapath.
//
// Channel   Dir  Beat
// in        in   target_rate_hz
// out       out  status, trigger_interval, integer_divider, frac_numerator,
//                frac_denominator
// cfg       in   source_clock_hz (cfg_we, cfg_wdata)
//
// A solved rate runs a scale divide, a quotient divide and one rounding
// divide per search step, steps up to 63, all on the shared one-bit-per-cycle
// 34-bit divider; a zero remainder skips the search.
// Rates below 80 Hz or too high skip the divides and the search.
// Reset clears the controller and sets source_clock_hz to 80 MHz.
// A stalled result waits in the output register; the next beat is taken
// meanwhile but its result holds until the register frees.
module fractional_clock_divider_solver_core import fcd_pkg::*; #(
    parameter int BASE_INTERVAL = 4000,
    parameter int DENOM_LIMIT   = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [SRC_W-1:0] cfg_wdata,
    fcd_in_if.sink           in_ch,
    fcd_out_if.source        out_ch
);
    logic [SRC_W-1:0] src_reg;
    fcd_cmd_t         cmd;
    fcd_stat_t        stat;

    // Hold the source clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= 28'd80000000;
        end
        else if (cfg_we)
        begin
            src_reg <= cfg_wdata;
        end
    end

    fcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fcd_datapath #(
        .BASE_INTERVAL (BASE_INTERVAL),
        .DENOM_LIMIT   (DENOM_LIMIT)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .source_clock_hz  (src_reg),
        .rate_in          (in_ch.target_rate_hz),
        .cmd              (cmd),
        .stat             (stat),
        .status           (out_ch.status),
        .trigger_interval (out_ch.trigger_interval),
        .integer_divider  (out_ch.integer_divider),
        .frac_numerator   (out_ch.frac_numerator),
        .frac_denominator (out_ch.frac_denominator)
    );
endmodule

### sv/fcd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on fcd_pkg.
module fcd_divider import fcd_pkg::*; #(
    parameter int W = 36
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // One shift-subtract step per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

### sv/fcd_datapath.sv
// Datapath of the divider solver: interval, divides, denominator search.
// Depends on fcd_pkg, fcd_divider.
module fcd_datapath import fcd_pkg::*; #(
    parameter int BASE_INTERVAL = 4000,
    parameter int DENOM_LIMIT   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SRC_W-1:0]  source_clock_hz,
    input  logic [RATE_W-1:0] rate_in,
    input  fcd_cmd_t          cmd,
    output fcd_stat_t         stat,
    output logic [1:0]        status,
    output logic [11:0]       trigger_interval,
    output logic [9:0]        integer_divider,
    output logic [5:0]        frac_numerator,
    output logic [5:0]        frac_denominator
);
    localparam int BW = $clog2(DENOM_LIMIT);
    localparam int IW = $clog2(BASE_INTERVAL + 1);
    localparam int DW = RATE_W + BW + 2; // divider width
    localparam int NW = RATE_W + BW;     // mod*b width
    // 20 kHz: first rate that doubles the multiple
    localparam longint unsigned STEP_HZ = 64'd20000;

    logic [RATE_W-1:0] rate_reg;
    logic [IW-1:0]     interval_reg;
    logic              low_reg, high_reg;
    logic [SRC_W-1:0]  scaled_reg;
    logic [RATE_W-1:0] mod_reg;
    logic [SRC_W-1:0]  quot_reg;
    logic [BW-1:0]     cb_reg;
    logic [NW-1:0]     num_reg;
    logic [NW:0]       best_reg;
    logic [BW-1:0]     a_reg, b_reg;
    logic              exact_reg;
    logic [1:0]        st_out_reg;
    logic [11:0]       int_out_reg;
    logic [9:0]        div_out_reg;
    logic [5:0]        a_out_reg, b_out_reg;

    // Interval from the incoming rate: the bit length of rate/20000 sets the
    // multiple, found by comparing against 20000 shifted left
    logic [5:0]        blen;
    logic [IW-1:0]     interval_c;
    always_comb
    begin
        blen = '0;
        for (int j = 0; j < RATE_W; j++)
        begin
            if ({{(64-RATE_W){1'b0}}, rate_in} >= (STEP_HZ << j))
            begin
                blen = 6'(j + 1);
            end
        end
        if (blen == '0)
        begin
            interval_c = IW'(BASE_INTERVAL);
        end
        else if (blen >= 6'(IW))
        begin
            interval_c = '0;
        end
        else
        begin
            interval_c = IW'(BASE_INTERVAL) >> blen;
        end
    end

    // Shared divider operand selection
    logic         dv_done;
    logic [DW-1:0] dv_q, dv_r, dv_n, dv_d;
    always_comb
    begin
        case (cmd.div_sel)
            DSEL_SCALE:
            begin
                dv_n = DW'(source_clock_hz);
                dv_d = DW'(interval_reg);
            end
            DSEL_QUOT:
            begin
                dv_n = DW'(scaled_reg);
                dv_d = DW'(rate_reg);
            end
            DSEL_ROUND:
            begin
                dv_n = DW'({num_reg, 1'b0}) + DW'(rate_reg);
                dv_d = DW'({rate_reg, 1'b0});
            end
            default:
            begin
                dv_n = '0;
                dv_d = '1;
            end
        endcase
    end

    fcd_divider #(.W(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dv_n),
        .divisor   (dv_d),
        .done      (dv_done),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    // Candidate error from the rounded numerator
    logic [NW+BW-1:0] prod;
    logic [NW:0]      err;
    assign prod = (NW+BW)'(rate_reg) * (NW+BW)'(dv_q[BW-1:0]);
    always_comb
    begin
        if ({{BW{1'b0}}, num_reg} >= prod)
        begin
            err = (NW+1)'({{BW{1'b0}}, num_reg} - prod);
        end
        else
        begin
            err = (NW+1)'(prod - {{BW{1'b0}}, num_reg});
        end
    end

    // Capture, divide results, search bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rate_reg     <= rate_in;
            interval_reg <= interval_c;
            low_reg      <= rate_in < MIN_RATE;
            high_reg     <= interval_c == '0;
        end
        if (dv_done && cmd.div_sel == DSEL_SCALE)
        begin
            scaled_reg <= dv_q[SRC_W-1:0];
        end
        if (dv_done && cmd.div_sel == DSEL_QUOT)
        begin
            quot_reg <= dv_q[SRC_W-1:0];
            mod_reg  <= dv_r[RATE_W-1:0];
        end
        if (cmd.cand_init)
        begin
            cb_reg    <= BW'(1);
            num_reg   <= NW'(mod_reg);
            best_reg  <= (NW+1)'(mod_reg) + 1'b1;
            a_reg     <= '0;
            b_reg     <= BW'(1);
            exact_reg <= 1'b0;
        end
        else if (cmd.cand_eval)
        begin
            if (err == '0)
            begin
                exact_reg <= 1'b1;
                a_reg     <= dv_q[BW-1:0];
                b_reg     <= cb_reg;
            end
            else if (err < best_reg)
            begin
                best_reg <= err;
                a_reg    <= dv_q[BW-1:0];
                b_reg    <= cb_reg;
            end
            cb_reg  <= cb_reg + 1'b1;
            num_reg <= num_reg + NW'(mod_reg);
        end
        if (cmd.out_load)
        begin
            if (low_reg)
            begin
                st_out_reg <= ST_LOW;
            end
            else if (high_reg)
            begin
                st_out_reg <= ST_HIGH;
            end
            else
            begin
                st_out_reg <= ST_OK;
            end
            if (low_reg || high_reg)
            begin
                int_out_reg <= '0;
                div_out_reg <= '0;
                a_out_reg   <= '0;
                b_out_reg   <= 6'd1;
            end
            else
            begin
                int_out_reg <= 12'(interval_reg);
                div_out_reg <= (quot_reg > SRC_W'(DIV_MAX)) ? DIV_MAX : quot_reg[9:0];
                a_out_reg   <= (mod_reg == '0) ? 6'd0 : 6'(a_reg);
                b_out_reg   <= (mod_reg == '0) ? 6'd1 : 6'(b_reg);
            end
        end
    end

    // Search ends on an exact match or once the last denominator is done
    assign stat.div_done   = dv_done;
    assign stat.bad_low    = low_reg;
    assign stat.bad_high   = high_reg;
    assign stat.mod_zero   = mod_reg == '0;
    assign stat.search_end = exact_reg || cb_reg == BW'(DENOM_LIMIT);

    assign status           = st_out_reg;
    assign trigger_interval = int_out_reg;
    assign integer_divider  = div_out_reg;
    assign frac_numerator   = a_out_reg;
    assign frac_denominator = b_out_reg;
endmodule

### sv/fcd_ctrl.sv
// Controller of the divider solver: sequences divides and the search.
// Depends on fcd_pkg.
module fcd_ctrl import fcd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  fcd_stat_t stat,
    output fcd_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_QUOT  = 3'd3;
    localparam logic [2:0] S_INIT  = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;
    localparam logic [2:0] S_NEXT  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       pend_reg, pend_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        pend_next   = pend_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.div_sel = DSEL_SCALE;
                if (stat.bad_low || stat.bad_high)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.div_sel = DSEL_SCALE;
                if (stat.div_done)
                begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                cmd.div_sel = DSEL_QUOT;
                if (!pend_reg)
                begin
                    cmd.div_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (stat.div_done)
                begin
                    pend_next  = 1'b0;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.cand_init = 1'b1;
                state_next    = S_NEXT;
            end
            S_NEXT:
            begin
                cmd.div_sel = DSEL_ROUND;
                if (stat.mod_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.div_sel = DSEL_ROUND;
                if (stat.div_done)
                begin
                    cmd.cand_eval = 1'b1;
                    state_next    = S_DONE;
                    pend_next     = 1'b1;
                end
            end
            S_DONE:
            begin
                // pend marks a search step just evaluated
                if (pend_reg && !stat.search_end)
                begin
                    pend_next  = 1'b0;
                    state_next = S_NEXT;
                end
                else if (!ovalid_reg || out_ready)
                begin
                    pend_next   = 1'b0;
                    cmd.out_load = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ovalid_reg;
endmodule

### sv/fcd_checker.sv
// Port-level checker for the fractional clock divider solver, with bind.
// Depends on fcd_pkg and the top level's ports.
module fcd_checker import fcd_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [11:0] trigger_interval,
    input logic [5:0]  frac_denominator
);
    // Output stays valid with a stable status while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped or changed under stall");

    // Status code is never the unused value
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");

    // Error results carry zero interval
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> trigger_interval == 12'd0)
        else $error("error result has interval");

    // Denominator never zero
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frac_denominator != 6'd0)
        else $error("zero denominator");
endmodule

bind fractional_clock_divider_solver_core fcd_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .status           (out_ch.status),
    .trigger_interval (out_ch.trigger_interval),
    .frac_denominator (out_ch.frac_denominator)
);

### verif/tb_top.sv
// Testbench for the fractional clock divider solver core.
// Drives target rates over valid/ready channels, predicts divider settings.
// Depends on fcd_pkg, fcd_if and the RTL top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fcd_pkg::*;

    localparam int ITEM_CYCLES = 2600;
    localparam int CYCLE_LIMIT = ITEM_CYCLES * 300 * 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] trigger_interval;
        logic [9:0]  integer_divider;
        logic [5:0]  frac_numerator;
        logic [5:0]  frac_denominator;
    } divider_setting_t;

    typedef struct {
        logic [RATE_W-1:0] rate;
        logic              known;
        divider_setting_t  setting;
    } rate_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [SRC_W-1:0] cfg_wdata = '0;
    logic [SRC_W-1:0] src_clock_hz;
    int failures = 0;
    int cycle_count = 0;
    bit hold_off = 1'b0;
    divider_setting_t pending_settings[$];

    fcd_in_if  in_ch ();
    fcd_out_if out_ch ();

    fractional_clock_divider_solver_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    always #1 clk = ~clk;

    // Count cycles and stop a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int bit_len(longint unsigned v);
        int n;
        n = 0;
        while (v != 0)
        begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    // Solve divider settings for one rate under the current source clock
    function automatic divider_setting_t solve_divider(logic [RATE_W-1:0] rate_in);
        divider_setting_t s;
        longint unsigned rate, khz, mult, interval, scaled, quot, rem_v;
        longint unsigned best, num, ca, prod, err;
        int cb;
        s = '{status: ST_OK, trigger_interval: '0, integer_divider: '0,
              frac_numerator: '0, frac_denominator: 6'd1};
        rate = rate_in;
        if (rate < MIN_RATE)
        begin
            s.status = ST_LOW;
            return s;
        end
        khz = rate / 1000;
        mult = (khz < 20) ? 1 : (longint'(1) << bit_len(khz / 20));
        interval = 4000 / mult;
        if (interval == 0)
        begin
            s.status = ST_HIGH;
            return s;
        end
        scaled = src_clock_hz / interval;
        quot = scaled / rate;
        rem_v = scaled % rate;
        if (rem_v != 0)
        begin
            best = rem_v + 1;
            for (cb = 1; cb < 64; cb++)
            begin
                num = rem_v * cb;
                ca = (2 * num + rate) / (2 * rate);
                prod = rate * ca;
                err = (num >= prod) ? num - prod : prod - num;
                if (err == 0)
                begin
                    s.frac_numerator = ca[5:0];
                    s.frac_denominator = cb[5:0];
                    break;
                end
                if (err < best)
                begin
                    best = err;
                    s.frac_numerator = ca[5:0];
                    s.frac_denominator = cb[5:0];
                end
            end
        end
        s.trigger_interval = interval[11:0];
        s.integer_divider = (quot > 1023) ? DIV_MAX : quot[9:0];
        return s;
    endfunction

    // Receive side: random stalls, long hold-off on request, field checks
    initial
    begin
        divider_setting_t got, want;
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ch.ready = 1'b0;
                repeat (8000) @(negedge clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            out_ch.ready = 1'b0;
            repeat (gap) @(negedge clk);
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got = '{out_ch.status, out_ch.trigger_interval, out_ch.integer_divider,
                    out_ch.frac_numerator, out_ch.frac_denominator};
            if (pending_settings.size() == 0)
            begin
                $error("result beat with no expected setting");
                failures++;
            end
            else
            begin
                want = pending_settings.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    failures++;
                end
                if (got.trigger_interval !== want.trigger_interval)
                begin
                    $error("trigger_interval exp %0d got %0d",
                        want.trigger_interval, got.trigger_interval);
                    failures++;
                end
                if (got.integer_divider !== want.integer_divider)
                begin
                    $error("integer_divider exp %0d got %0d",
                        want.integer_divider, got.integer_divider);
                    failures++;
                end
                if (got.frac_numerator !== want.frac_numerator)
                begin
                    $error("frac_numerator exp %0d got %0d",
                        want.frac_numerator, got.frac_numerator);
                    failures++;
                end
                if (got.frac_denominator !== want.frac_denominator)
                begin
                    $error("frac_denominator exp %0d got %0d",
                        want.frac_denominator, got.frac_denominator);
                    failures++;
                end
            end
        end
    end

    // Send one rate beat after a random gap; queue its predicted setting
    task automatic send_rate(logic [RATE_W-1:0] rate, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.target_rate_hz <= rate;
        do @(posedge clk); while (!in_ch.ready);
        pending_settings.push_back(solve_divider(rate));
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_settings.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_source(logic [SRC_W-1:0] hz);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= hz;
        src_clock_hz = hz;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random rate: mostly valid band, some low and too-high, some full width
    function automatic logic [RATE_W-1:0] random_rate();
        case ($urandom_range(0, 9))
            0: return RATE_W'($urandom_range(0, 100));
            1: return RATE_W'($urandom_range(1500000, 67108863));
            2: return RATE_W'($urandom_range(0, 67108863));
            3: return RATE_W'($urandom_range(80, 2000));
            default: return RATE_W'($urandom_range(80, 1300000));
        endcase
    endfunction

    initial
    begin
        rate_row_t directed[$];
        rate_row_t row;
        logic [SRC_W-1:0] sources[5];
        int p;
        in_ch.valid = 1'b0;
        in_ch.target_rate_hz = '0;
        src_clock_hz = 28'd80000000;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: known rows are read off the rules, rest predicted
        directed = '{
            '{26'd0, 1, '{ST_LOW, 12'd0, 10'd0, 6'd0, 6'd1}},
            '{26'd79, 1, '{ST_LOW, 12'd0, 10'd0, 6'd0, 6'd1}},
            '{26'd80, 1, '{ST_OK, 12'd4000, 10'd250, 6'd0, 6'd1}},
            '{26'd1000, 1, '{ST_OK, 12'd4000, 10'd20, 6'd0, 6'd1}},
            '{26'd67108863, 1, '{ST_HIGH, 12'd0, 10'd0, 6'd0, 6'd1}},
            '{26'd3, 0, '0}, '{26'd81, 0, '0}, '{26'd19999, 0, '0},
            '{26'd20000, 0, '0}, '{26'd39999, 0, '0}, '{26'd40000, 0, '0},
            '{26'd333, 0, '0}, '{26'd777, 0, '0}, '{26'd1279999, 0, '0},
            '{26'd1280000, 0, '0}, '{26'd2559999, 0, '0}, '{26'd2560000, 0, '0},
            '{26'd44100, 0, '0}, '{26'd48000, 0, '0}, '{26'd33554432, 0, '0}
        };
        foreach (directed[i])
        begin
            row = directed[i];
            if (row.known && solve_divider(row.rate) !== row.setting)
            begin
                $error("predictor disagrees on rate %0d", row.rate);
                failures++;
            end
            send_rate(row.rate, 1'b0);
        end

        // Random phases across source clock settings, extremes included
        sources = '{28'd1000000, 28'd240000000, 28'd0, 28'hFFFFFFF, 28'd0};
        for (p = 0; p < 5; p++)
        begin
            set_source(p == 4 ? 28'($urandom_range(1000000, 240000000)) : sources[p]);
            if (p == 1)
                hold_off = 1'b1;
            repeat (50) send_rate(random_rate(), ($urandom_range(0, 4) == 0));
            if (p == 2)
                drain();
        end
        drain();
        repeat (200) @(negedge clk);
        if (failures == 0 && pending_settings.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
sv/fcd_pkg.sv
sv/fcd_if.sv
sv/fcd_divider.sv
sv/fcd_datapath.sv
sv/fcd_ctrl.sv
sv/fractional_clock_divider_solver_core.sv
sv/fcd_checker.sv
verif/tb_top.sv
